FILE: hw/rtl/spi_eas_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spi_eas_pkg
// Shared types and codes for the SPI EEPROM access sequencer.
// ----------------------------------------------------------------------------
package spi_eas_pkg;

    // request opcodes carried with each tick
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // sequence steps
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_RCMD  = 4'd1;
    localparam logic [3:0] ST_RADDR = 4'd2;
    localparam logic [3:0] ST_RDATA = 4'd3;
    localparam logic [3:0] ST_WREN  = 4'd4;
    localparam logic [3:0] ST_WGAP  = 4'd5;
    localparam logic [3:0] ST_WCMD  = 4'd6;
    localparam logic [3:0] ST_WADDR = 4'd7;
    localparam logic [3:0] ST_WDATA = 4'd8;
    localparam logic [3:0] ST_SGAP  = 4'd9;
    localparam logic [3:0] ST_SCMD  = 4'd10;
    localparam logic [3:0] ST_SREAD = 4'd11;

    // EEPROM command bytes
    localparam logic [7:0] CMD_READ  = 8'h03;
    localparam logic [7:0] CMD_WRITE = 8'h02;
    localparam logic [7:0] CMD_WREN  = 8'h06;
    localparam logic [7:0] CMD_RDSR  = 8'h05;

    // status register write-in-progress bit
    localparam int unsigned STATUS_WIP_BIT = 0;

    localparam logic [2:0] LAST_BIT = 3'd7;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] address;
        logic [7:0] write_data;
        logic       miso;
    } t_in_req;

    typedef struct packed {
        logic       chip_select_n;
        logic       serial_clock;
        logic       mosi;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       rejected;
    } t_out_res;

endpackage
`default_nettype wire

FILE: hw/rtl/spi_eeprom_access_sequencer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spi_eeprom_access_sequencer_core
// SPI mode-0 master sequencer for an 8-bit-address serial EEPROM.
// ----------------------------------------------------------------------------
// Each request on the input channel is one half-bit tick of the SPI bus and
// returns exactly one response: the chip select, clock and MOSI levels for
// that tick plus busy/done/read data/rejected status. The block takes one
// tick per clock cycle while the output is not stalled; the next state is
// worked out from the sequencer registers and the incoming tick in a single
// pass and lands in the output register in the same edge, so throughput is
// one request per cycle. The output register is the only buffer: the input
// stalls only while a response sits unaccepted and the output is stalled.
// A bit takes two ticks (clock low drives MOSI, clock high samples MISO).
// A read is 0x03, address, one byte in: 49 ticks including the accepting
// tick. A write is 0x06, one chip-select-high gap, 0x02, address, data, then
// gap plus 0x05 status read repeated until write-in-progress clears.
// Requests that arrive while busy (done tick included) are flagged rejected
// and otherwise ignored.
// ----------------------------------------------------------------------------
module spi_eeprom_access_sequencer_core (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_stall,
    input  spi_eas_pkg::t_in_req   i_in_data,
    output logic                   o_out_valid,
    input  wire                    i_out_stall,
    output spi_eas_pkg::t_out_res  o_out_data
);

    // sequencer state
    logic [3:0] r_step,     n_step;
    logic [2:0] r_bit_cnt,  n_bit_cnt;
    logic       r_phase,    n_phase;
    logic [7:0] r_tx,       n_tx;
    logic [7:0] r_rx,       n_rx;
    logic [7:0] r_addr,     n_addr;
    logic [7:0] r_byte,     n_byte;

    // output register
    logic                  r_out_valid;
    spi_eas_pkg::t_out_res r_out, n_out;

    logic w_accept;
    logic w_is_req;
    logic w_receiving;
    logic [7:0] w_rx_shift;

    // byte loaded into the transmit shifter when a step is entered
    function automatic logic [7:0] byte_for(input logic [3:0] step,
                                            input logic [7:0] addr,
                                            input logic [7:0] data);
        logic [7:0] b;
        unique case (step) inside
            spi_eas_pkg::ST_RCMD:  b = spi_eas_pkg::CMD_READ;
            spi_eas_pkg::ST_RADDR,
            spi_eas_pkg::ST_WADDR: b = addr;
            spi_eas_pkg::ST_WREN:  b = spi_eas_pkg::CMD_WREN;
            spi_eas_pkg::ST_WCMD:  b = spi_eas_pkg::CMD_WRITE;
            spi_eas_pkg::ST_WDATA: b = data;
            spi_eas_pkg::ST_SCMD:  b = spi_eas_pkg::CMD_RDSR;
            default:               b = 8'h00;
        endcase
        return b;
    endfunction

    assign o_in_stall  = r_out_valid & i_out_stall;
    assign w_accept    = i_in_valid & ~o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign w_is_req    = (i_in_data.opcode == spi_eas_pkg::OP_READ) ||
                         (i_in_data.opcode == spi_eas_pkg::OP_WRITE);
    assign w_receiving = (r_step == spi_eas_pkg::ST_RDATA) ||
                         (r_step == spi_eas_pkg::ST_SREAD);
    assign w_rx_shift  = {r_rx[6:0], i_in_data.miso};

    always_comb begin
        n_step    = r_step;
        n_bit_cnt = r_bit_cnt;
        n_phase   = r_phase;
        n_tx      = r_tx;
        n_rx      = r_rx;
        n_addr    = r_addr;
        n_byte    = r_byte;

        n_out               = '0;
        n_out.chip_select_n = 1'b1;

        unique case (r_step) inside
            spi_eas_pkg::ST_WGAP, spi_eas_pkg::ST_SGAP: begin
                // chip select high for one tick, then next command
                n_out.busy_res = 1'b1;
                n_out.rejected = w_is_req;
                n_step    = (r_step == spi_eas_pkg::ST_WGAP) ? spi_eas_pkg::ST_WCMD
                                                             : spi_eas_pkg::ST_SCMD;
                n_bit_cnt = '0;
                n_phase   = 1'b0;
                n_tx      = byte_for(n_step, r_addr, r_byte);
            end
            spi_eas_pkg::ST_RCMD,  spi_eas_pkg::ST_RADDR, spi_eas_pkg::ST_RDATA,
            spi_eas_pkg::ST_WREN,  spi_eas_pkg::ST_WCMD,  spi_eas_pkg::ST_WADDR,
            spi_eas_pkg::ST_WDATA, spi_eas_pkg::ST_SCMD,  spi_eas_pkg::ST_SREAD: begin
                n_out.busy_res      = 1'b1;
                n_out.rejected      = w_is_req;
                n_out.chip_select_n = 1'b0;
                n_out.serial_clock  = r_phase;
                n_out.mosi          = w_receiving ? 1'b0 : r_tx[7];
                if (!r_phase) begin
                    n_phase = 1'b1;
                end else begin
                    // high phase: sample MISO, advance the bit
                    n_phase = 1'b0;
                    if (w_receiving) begin
                        n_rx = w_rx_shift;
                    end
                    n_tx = {r_tx[6:0], 1'b0};
                    if (r_bit_cnt != spi_eas_pkg::LAST_BIT) begin
                        n_bit_cnt = r_bit_cnt + 3'd1;
                    end else begin
                        n_bit_cnt = '0;
                        unique case (r_step)
                            spi_eas_pkg::ST_RCMD:  n_step = spi_eas_pkg::ST_RADDR;
                            spi_eas_pkg::ST_RADDR: n_step = spi_eas_pkg::ST_RDATA;
                            spi_eas_pkg::ST_RDATA: begin
                                n_out.done_res  = 1'b1;
                                n_out.read_data = w_rx_shift;
                                n_step          = spi_eas_pkg::ST_IDLE;
                            end
                            spi_eas_pkg::ST_WREN:  n_step = spi_eas_pkg::ST_WGAP;
                            spi_eas_pkg::ST_WCMD:  n_step = spi_eas_pkg::ST_WADDR;
                            spi_eas_pkg::ST_WADDR: n_step = spi_eas_pkg::ST_WDATA;
                            spi_eas_pkg::ST_WDATA: n_step = spi_eas_pkg::ST_SGAP;
                            spi_eas_pkg::ST_SCMD:  n_step = spi_eas_pkg::ST_SREAD;
                            default: begin
                                // status read: poll again while write in progress
                                if (w_rx_shift[spi_eas_pkg::STATUS_WIP_BIT]) begin
                                    n_step = spi_eas_pkg::ST_SGAP;
                                end else begin
                                    n_out.done_res = 1'b1;
                                    n_step         = spi_eas_pkg::ST_IDLE;
                                end
                            end
                        endcase
                        // entering a new byte step reloads the shifter
                        if ((n_step != spi_eas_pkg::ST_IDLE) &&
                            (n_step != spi_eas_pkg::ST_WGAP) &&
                            (n_step != spi_eas_pkg::ST_SGAP)) begin
                            n_tx = byte_for(n_step, r_addr, r_byte);
                        end
                    end
                end
            end
            default: begin
                // idle, and any unused code behaves as idle
                n_step = spi_eas_pkg::ST_IDLE;
                if (w_is_req) begin
                    n_addr    = i_in_data.address;
                    n_byte    = i_in_data.write_data;
                    n_step    = (i_in_data.opcode == spi_eas_pkg::OP_WRITE)
                                ? spi_eas_pkg::ST_WREN : spi_eas_pkg::ST_RCMD;
                    n_bit_cnt = '0;
                    n_phase   = 1'b0;
                    n_tx      = byte_for(n_step, i_in_data.address,
                                         i_in_data.write_data);
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step    <= spi_eas_pkg::ST_IDLE;
            r_bit_cnt <= '0;
            r_phase   <= 1'b0;
            r_tx      <= '0;
            r_rx      <= '0;
            r_addr    <= '0;
            r_byte    <= '0;
        end else if (w_accept) begin
            r_step    <= n_step;
            r_bit_cnt <= n_bit_cnt;
            r_phase   <= n_phase;
            r_tx      <= n_tx;
            r_rx      <= n_rx;
            r_addr    <= n_addr;
            r_byte    <= n_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out <= n_out;
        end
    end

    // idle always leaves the bit counter and clock phase at rest
    a_idle_rest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == spi_eas_pkg::ST_IDLE) |-> (r_bit_cnt == '0) && !r_phase)
        else $error("idle step with bit counter or phase not at rest");

    // gap steps are only reached after a completed byte
    a_gap_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_step == spi_eas_pkg::ST_WGAP) || (r_step == spi_eas_pkg::ST_SGAP))
        |-> !r_phase && (r_bit_cnt == '0))
        else $error("gap step entered mid-byte");

    // done is only reported by a running sequence
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.done_res) |-> o_out_data.busy_res)
        else $error("done without busy");

    // bus is quiet whenever chip select is released
    a_cs_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.chip_select_n)
        |-> !o_out_data.serial_clock && !o_out_data.mosi)
        else $error("clock or data active with chip select high");

endmodule
`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the SPI EEPROM access sequencer core.
// ----------------------------------------------------------------------------
// Every request is one half-bit tick of the SPI bus and returns one set of
// bus levels and status. A scripted opening checks idle levels after reset,
// the spare opcode, request accept and rejection while busy. Random traffic
// then runs read and write sequences end to end: plain ticks with random
// MISO, with stray requests dropped in while busy, on the done tick most of
// all. Every response is compared field by field with the scripted levels
// or a local model of the sequencer. Both handshake sides idle and stall at
// random, with calm stretches in between.
// ----------------------------------------------------------------------------
module tb;

    // opcode 3 has no package name; the core treats it as a plain tick
    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam int RAND_REQUESTS = 1435;

    typedef struct {
        spi_eas_pkg::t_in_req  req;
        bit                    typed;
        spi_eas_pkg::t_out_res want;
    } t_script_row;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    spi_eas_pkg::t_in_req  in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    spi_eas_pkg::t_out_res out_data;

    spi_eeprom_access_sequencer_core u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    initial begin
        forever #10 clk = ~clk;
    end

    // run limit: far above the slowest legal run
    initial begin
        #20_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sequencer model state, mirrors the core after reset
    // ------------------------------------------------------------------
    logic [3:0] seq_step  = spi_eas_pkg::ST_IDLE;
    logic [2:0] bit_idx   = '0;
    logic       sck_high  = 1'b0;
    logic [7:0] tx_shift  = '0;
    logic [7:0] rx_shift  = '0;
    logic [7:0] hold_addr = '0;
    logic [7:0] hold_data = '0;
    logic       write_job = 1'b0;

    spi_eas_pkg::t_out_res pending_levels[$];
    t_script_row           script[$];
    int                    mismatches = 0;
    bit                    calm = 1'b0;
    bit                    drive_on = 1'b0;

    function automatic spi_eas_pkg::t_out_res levels(logic cs_n, logic sck, logic mo,
                                                     logic busy, logic done,
                                                     logic [7:0] rd, logic rej);
        spi_eas_pkg::t_out_res o;
        o.chip_select_n = cs_n;
        o.serial_clock  = sck;
        o.mosi          = mo;
        o.busy_res      = busy;
        o.done_res      = done;
        o.read_data     = rd;
        o.rejected      = rej;
        return o;
    endfunction

    // start a byte phase: clock low, bit count cleared, shift loaded
    function automatic void enter_step(logic [3:0] nxt);
        seq_step = nxt;
        bit_idx  = '0;
        sck_high = 1'b0;
        case (nxt)
            spi_eas_pkg::ST_RCMD:  tx_shift = spi_eas_pkg::CMD_READ;
            spi_eas_pkg::ST_RADDR,
            spi_eas_pkg::ST_WADDR: tx_shift = hold_addr;
            spi_eas_pkg::ST_WREN:  tx_shift = spi_eas_pkg::CMD_WREN;
            spi_eas_pkg::ST_WCMD:  tx_shift = spi_eas_pkg::CMD_WRITE;
            spi_eas_pkg::ST_WDATA: tx_shift = hold_data;
            spi_eas_pkg::ST_SCMD:  tx_shift = spi_eas_pkg::CMD_RDSR;
            default:               tx_shift = '0;
        endcase
    endfunction

    // one half-bit tick: returns the levels the core must drive for it
    function automatic spi_eas_pkg::t_out_res spi_tick_predict(spi_eas_pkg::t_in_req r);
        spi_eas_pkg::t_out_res o;
        logic                  req_seen;
        logic                  rx_step;
        logic [3:0]            cur;
        o = levels(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
        req_seen = (r.opcode == spi_eas_pkg::OP_READ) ||
                   (r.opcode == spi_eas_pkg::OP_WRITE);
        cur = seq_step;
        if (cur == spi_eas_pkg::ST_IDLE || cur > spi_eas_pkg::ST_SREAD) begin
            // accepting tick: latch only, bus stays idle
            seq_step = spi_eas_pkg::ST_IDLE;
            if (req_seen) begin
                hold_addr = r.address;
                hold_data = r.write_data;
                write_job = (r.opcode == spi_eas_pkg::OP_WRITE);
                enter_step(write_job ? spi_eas_pkg::ST_WREN : spi_eas_pkg::ST_RCMD);
            end
        end else if (cur == spi_eas_pkg::ST_WGAP || cur == spi_eas_pkg::ST_SGAP) begin
            // chip select high for one tick between commands
            o.busy_res = 1'b1;
            o.rejected = req_seen;
            enter_step(cur == spi_eas_pkg::ST_WGAP ? spi_eas_pkg::ST_WCMD
                                                   : spi_eas_pkg::ST_SCMD);
        end else begin
            rx_step = (cur == spi_eas_pkg::ST_RDATA) || (cur == spi_eas_pkg::ST_SREAD);
            o.busy_res      = 1'b1;
            o.rejected      = req_seen;
            o.chip_select_n = 1'b0;
            o.serial_clock  = sck_high;
            o.mosi          = rx_step ? 1'b0 : tx_shift[7];
            if (!sck_high) begin
                sck_high = 1'b1;
            end else begin
                // high phase: sample MISO, move to next bit
                sck_high = 1'b0;
                if (rx_step)
                    rx_shift = {rx_shift[6:0], r.miso};
                tx_shift = tx_shift << 1;
                if (bit_idx != spi_eas_pkg::LAST_BIT) begin
                    bit_idx = bit_idx + 3'd1;
                end else begin
                    bit_idx = '0;
                    case (cur)
                        spi_eas_pkg::ST_RCMD:  enter_step(spi_eas_pkg::ST_RADDR);
                        spi_eas_pkg::ST_RADDR: enter_step(spi_eas_pkg::ST_RDATA);
                        spi_eas_pkg::ST_RDATA: begin
                            o.done_res  = 1'b1;
                            o.read_data = rx_shift;
                            seq_step    = spi_eas_pkg::ST_IDLE;
                        end
                        spi_eas_pkg::ST_WREN:  seq_step = spi_eas_pkg::ST_WGAP;
                        spi_eas_pkg::ST_WCMD:  enter_step(spi_eas_pkg::ST_WADDR);
                        spi_eas_pkg::ST_WADDR: enter_step(spi_eas_pkg::ST_WDATA);
                        spi_eas_pkg::ST_WDATA: seq_step = spi_eas_pkg::ST_SGAP;
                        spi_eas_pkg::ST_SCMD:  enter_step(spi_eas_pkg::ST_SREAD);
                        default: begin
                            // status read: poll again while write in progress
                            if (rx_shift[spi_eas_pkg::STATUS_WIP_BIT]) begin
                                seq_step = spi_eas_pkg::ST_SGAP;
                            end else begin
                                o.done_res = 1'b1;
                                seq_step   = spi_eas_pkg::ST_IDLE;
                            end
                        end
                    endcase
                end
            end
        end
        return o;
    endfunction

    function automatic void script_row(logic [1:0] op, logic [7:0] a, logic [7:0] d,
                                       logic mi, bit typed, spi_eas_pkg::t_out_res want);
        t_script_row row;
        row.req.opcode     = op;
        row.req.address    = a;
        row.req.write_data = d;
        row.req.miso       = mi;
        row.typed          = typed;
        row.want           = want;
        script.push_back(row);
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 5))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Request side: hold each tick until taken, then predict its levels
    // ------------------------------------------------------------------
    task automatic send_tick(input spi_eas_pkg::t_in_req r, input bit typed,
                             input spi_eas_pkg::t_out_res want);
        int                    gap;
        spi_eas_pkg::t_out_res guess;
        gap = calm ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            if (drive_on) begin
                in_valid <= 1'b0;
                drive_on = 1'b0;
            end
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= r;
        drive_on = 1'b1;
        do @(posedge clk); while (in_stall);
        guess = spi_tick_predict(r);
        pending_levels.push_back(typed ? want : guess);
    endtask

    // stop sending until every expected response is back
    task automatic drain_responses();
        if (drive_on) begin
            in_valid <= 1'b0;
            drive_on = 1'b0;
        end
        do @(posedge clk); while (pending_levels.size() != 0);
    endtask

    // ------------------------------------------------------------------
    // Response side: random stall per response
    // ------------------------------------------------------------------
    initial begin : response_sink
        int hold;
        forever begin
            hold = calm ? 0 : $urandom_range(0, 9);
            if (hold != 0) begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1 || !rst_n);
        end
    end

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want) begin
            $display("%0t ns: %s expected %h got %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk) begin : response_check
        spi_eas_pkg::t_out_res want;
        if (rst_n && out_valid === 1'b1 && !out_stall) begin
            if (pending_levels.size() == 0) begin
                $display("%0t ns: unexpected response, expected none got %h",
                         $time, out_data);
                mismatches++;
            end else begin
                want = pending_levels.pop_front();
                check_field("chip_select_n", 8'(want.chip_select_n), 8'(out_data.chip_select_n));
                check_field("serial_clock", 8'(want.serial_clock), 8'(out_data.serial_clock));
                check_field("mosi", 8'(want.mosi), 8'(out_data.mosi));
                check_field("busy_res", 8'(want.busy_res), 8'(out_data.busy_res));
                check_field("done_res", 8'(want.done_res), 8'(out_data.done_res));
                check_field("read_data", want.read_data, out_data.read_data);
                check_field("rejected", 8'(want.rejected), 8'(out_data.rejected));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : stimulus
        spi_eas_pkg::t_in_req  r;
        spi_eas_pkg::t_out_res idle_lv;
        int                    counted;
        int                    roll;
        bit                    idle_now;
        bit                    done_edge;
        bit                    paused;

        idle_lv = levels(1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0);
        // opening script
        script_row(spi_eas_pkg::OP_TICK, 8'h00, 8'h00, 1'b0, 1'b1, idle_lv);
        script_row(OP_SPARE, 8'hFF, 8'hFF, 1'b1, 1'b1, idle_lv);
        // read accept: latched, bus idle this tick
        script_row(spi_eas_pkg::OP_READ, 8'hFF, 8'h00, 1'b1, 1'b1, idle_lv);
        // requests during the read command byte are rejected
        script_row(spi_eas_pkg::OP_WRITE, 8'h00, 8'hFF, 1'b0, 1'b1,
                   levels(1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b1));
        script_row(spi_eas_pkg::OP_READ, 8'h5A, 8'hA5, 1'b1, 1'b1,
                   levels(1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 8'h00, 1'b1));
        script_row(OP_SPARE, 8'h00, 8'h00, 1'b0, 1'b0, idle_lv);
        for (int k = 0; k < 10; k++)
            script_row(spi_eas_pkg::OP_TICK, 8'h80 >> (k % 8), 8'h01 << (k % 8),
                       1'(k % 3), 1'b0, idle_lv);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[k])
            send_tick(script[k].req, script[k].typed, script[k].want);

        drain_responses();

        // random traffic: full sequences, stray requests while busy
        counted = 0;
        paused  = 1'b0;
        while (counted < RAND_REQUESTS) begin
            calm = ((counted / 150) % 4) == 3;
            r.address    = pick_byte();
            r.write_data = pick_byte();
            r.miso       = 1'($urandom_range(0, 1));
            idle_now = (seq_step == spi_eas_pkg::ST_IDLE) ||
                       (seq_step > spi_eas_pkg::ST_SREAD);
            if (idle_now) begin
                roll = $urandom_range(0, 9);
                if (roll == 0)
                    r.opcode = spi_eas_pkg::OP_TICK;
                else if (roll == 1)
                    r.opcode = OP_SPARE;
                else
                    r.opcode = (roll < 6) ? spi_eas_pkg::OP_READ : spi_eas_pkg::OP_WRITE;
            end else begin
                // last high tick of a request is the done tick, still busy
                done_edge = (seq_step == spi_eas_pkg::ST_RDATA ||
                             seq_step == spi_eas_pkg::ST_SREAD)
                            && bit_idx == spi_eas_pkg::LAST_BIT && sck_high;
                roll = $urandom_range(0, 31);
                if (roll == 0 || (done_edge && roll < 16))
                    r.opcode = $urandom_range(0, 1) ? spi_eas_pkg::OP_READ
                                                    : spi_eas_pkg::OP_WRITE;
                else if (roll == 1)
                    r.opcode = OP_SPARE;
                else
                    r.opcode = spi_eas_pkg::OP_TICK;
            end
            send_tick(r, 1'b0, idle_lv);
            // idle ticks without a request do not count
            if (!idle_now || r.opcode == spi_eas_pkg::OP_READ ||
                r.opcode == spi_eas_pkg::OP_WRITE)
                counted++;
            if (!paused && counted >= RAND_REQUESTS / 2) begin
                paused = 1'b1;
                drain_responses();
            end
        end

        drain_responses();
        repeat (8) @(posedge clk);
        if (mismatches == 0 && pending_levels.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
